### rtl/rbp_pkg.sv
// ---------------------------------------------------------------------------
// rbp_pkg - shared types and constants for the replicate border padder
// Dimension limits, field widths, register indexes and the span word that
// passes from the front end to the back end.
// ---------------------------------------------------------------------------
`default_nettype none

package rbp_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

  // register and field widths
  localparam int DIM_W   = 12;
  localparam int PAD_W   = 3;
  localparam int PIX_W   = 8;
  localparam int POS_W   = 12;
  localparam int CFG_IDX_W = 2;

  // position counters hold 0 .. MAX_DIM-1
  localparam int CNT_W = $clog2(MAX_DIM);

  // result cap per input word
  localparam int RESULT_CAP = 64;
  localparam int RUN_W      = $clog2(RESULT_CAP);

  // span queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_WIDTH    = 2'd2;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(2048);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(2048);
  localparam logic [PAD_W-1:0] PAD_WIDTH_RST    = PAD_W'(4);

  // one input word turned into the rectangle it covers in the padded frame
  typedef struct packed {
    logic [POS_W-1:0] row_lo;
    logic [POS_W-1:0] row_hi;
    logic [POS_W-1:0] col_lo;
    logic [POS_W-1:0] col_hi;
    logic [PIX_W-1:0] value;
  } span_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

### rtl/replicate_border_padder.sv
// ---------------------------------------------------------------------------
// replicate_border_padder - clamp-to-edge border padding, scatter form
// Each luma pixel of a raster-order frame is sent to every position it fills
// in a frame padded by pad_width pixels on all four sides.
// ---------------------------------------------------------------------------
// Channels: pixel words on in_valid/in_ready/pixel_in; results on
//   out_valid/out_ready with out_row, out_col, out_value and last_of_run,
//   which marks the final result of each pixel; register writes on
//   cfg_valid/cfg_ready/cfg_index/cfg_data (0 frame_width, 1 frame_height,
//   2 pad_width). cfg_ready is always high; write only while idle.
// Path: span queue, back end span register, then the output register.
// Throughput: the back end's row/column walk gives one result per cycle unless
//   the receiver stalls. Results per pixel: one inside, pad_width+1 on an edge,
//   (pad_width+1)^2 at a corner, 2*pad_width+1 along an axis of size one; cap 64.
// The front end keeps taking pixels while a 4-word span queue has room, so
//   short runs hide behind long corner bursts.
// Reset: counters go to the top-left pixel, queue and output empty,
//   registers to 2048 x 2048 with a 4-pixel border.
// Receiver stall: the output register holds its word; the back end stops,
//   then the queue fills and in_ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module replicate_border_padder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rbp_pkg::DIM_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rbp_pkg::PIX_W-1:0]     pixel_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rbp_pkg::POS_W-1:0]          out_row,
  output logic [rbp_pkg::POS_W-1:0]          out_col,
  output logic [rbp_pkg::PIX_W-1:0]          out_value,
  output logic                               last_of_run
);

  rbp_pkg::fifo_stat_t fifo_stat;
  rbp_pkg::span_t      push_data;
  rbp_pkg::span_t      pop_data;
  logic                push;
  logic                pop;

  // front: registers, counters, span classification
  rbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_in  (pixel_in),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_data (push_data)
  );

  // span queue decoupling the two halves
  rbp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (fifo_stat)
  );

  // back: rectangle walk into the output register
  rbp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .fifo_stat   (fifo_stat),
    .pop_data    (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_value   (out_value),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

### rtl/rbp_front.sv
// ---------------------------------------------------------------------------
// rbp_front - config registers, raster counters and span classification
// Tracks the position of the next pixel and turns each accepted pixel into
// the rectangle of padded positions it covers.
// ---------------------------------------------------------------------------
`default_nettype none

module rbp_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rbp_pkg::DIM_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rbp_pkg::PIX_W-1:0]     pixel_in,
  input  wire rbp_pkg::fifo_stat_t           fifo_stat,
  output logic                               push,
  output rbp_pkg::span_t                     push_data
);

  logic [rbp_pkg::DIM_W-1:0] frame_width;
  logic [rbp_pkg::DIM_W-1:0] frame_height;
  logic [rbp_pkg::PAD_W-1:0] pad_width;
  logic [rbp_pkg::CNT_W-1:0] col_count;
  logic [rbp_pkg::CNT_W-1:0] row_count;
  logic [rbp_pkg::CNT_W-1:0] col_count_next;
  logic [rbp_pkg::CNT_W-1:0] row_count_next;

  logic [rbp_pkg::DIM_W-1:0] w_eff;
  logic [rbp_pkg::DIM_W-1:0] h_eff;
  logic [rbp_pkg::CNT_W-1:0] col_pos;
  logic [rbp_pkg::CNT_W-1:0] row_pos;
  logic [rbp_pkg::DIM_W-1:0] col_inc;
  logic [rbp_pkg::DIM_W-1:0] row_inc;
  logic [rbp_pkg::POS_W-1:0] col_ext;
  logic [rbp_pkg::POS_W-1:0] row_ext;
  logic [rbp_pkg::POS_W-1:0] pad_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = !fifo_stat.full;
  assign push      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rbp_pkg::FRAME_WIDTH_RST;
      frame_height <= rbp_pkg::FRAME_HEIGHT_RST;
      pad_width    <= rbp_pkg::PAD_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rbp_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        rbp_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        rbp_pkg::CFG_PAD_WIDTH:    pad_width    <= cfg_data[rbp_pkg::PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (frame_width == '0) begin
      w_eff = rbp_pkg::DIM_W'(1);
    end else if (frame_width > rbp_pkg::DIM_W'(rbp_pkg::MAX_WIDTH)) begin
      w_eff = rbp_pkg::DIM_W'(rbp_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = rbp_pkg::DIM_W'(1);
    end else if (frame_height > rbp_pkg::DIM_W'(rbp_pkg::MAX_HEIGHT)) begin
      h_eff = rbp_pkg::DIM_W'(rbp_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  // counters left out of range by a size change restart at zero
  assign col_pos = (rbp_pkg::DIM_W'(col_count) >= w_eff) ? '0 : col_count;
  assign row_pos = (rbp_pkg::DIM_W'(row_count) >= h_eff) ? '0 : row_count;

  assign col_ext = rbp_pkg::POS_W'(col_pos);
  assign row_ext = rbp_pkg::POS_W'(row_pos);
  assign pad_ext = rbp_pkg::POS_W'(pad_width);

  always_comb begin
    push_data.value  = pixel_in;
    push_data.col_lo = (col_pos == '0) ? '0 : col_ext + pad_ext;
    push_data.col_hi = (rbp_pkg::DIM_W'(col_pos) == w_eff - rbp_pkg::DIM_W'(1)) ?
                       col_ext + (pad_ext << 1) : col_ext + pad_ext;
    push_data.row_lo = (row_pos == '0) ? '0 : row_ext + pad_ext;
    push_data.row_hi = (rbp_pkg::DIM_W'(row_pos) == h_eff - rbp_pkg::DIM_W'(1)) ?
                       row_ext + (pad_ext << 1) : row_ext + pad_ext;
  end

  assign col_inc = rbp_pkg::DIM_W'(col_pos) + rbp_pkg::DIM_W'(1);
  assign row_inc = rbp_pkg::DIM_W'(row_pos) + rbp_pkg::DIM_W'(1);

  always_comb begin
    if (col_inc >= w_eff) begin
      col_count_next = '0;
      row_count_next = (row_inc >= h_eff) ? '0 : rbp_pkg::CNT_W'(row_inc);
    end else begin
      col_count_next = rbp_pkg::CNT_W'(col_inc);
      row_count_next = row_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (push) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/rbp_fifo.sv
// ---------------------------------------------------------------------------
// rbp_fifo - short span queue between front and back end
// Register-based queue with a fill count; read word is the head entry.
// ---------------------------------------------------------------------------
`default_nettype none

module rbp_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire rbp_pkg::span_t push_data,
  input  wire logic           pop,
  output rbp_pkg::span_t      pop_data,
  output rbp_pkg::fifo_stat_t stat
);

  rbp_pkg::span_t mem [rbp_pkg::FIFO_DEPTH];
  logic [rbp_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [rbp_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [rbp_pkg::FIFO_PTR_W:0]   fill;

  assign stat.full  = (fill == (rbp_pkg::FIFO_PTR_W+1)'(rbp_pkg::FIFO_DEPTH));
  assign stat.empty = (fill == '0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/rbp_back.sv
// ---------------------------------------------------------------------------
// rbp_back - result sequencer
// Walks the span rectangle of each queued word in row-major order, up to the
// result cap, into the output register: one result per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module rbp_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire rbp_pkg::fifo_stat_t       fifo_stat,
  input  wire rbp_pkg::span_t            pop_data,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [rbp_pkg::POS_W-1:0]      out_row,
  output logic [rbp_pkg::POS_W-1:0]      out_col,
  output logic [rbp_pkg::PIX_W-1:0]      out_value,
  output logic                           last_of_run
);

  rbp_pkg::span_t              cur;
  logic                        active;
  logic [rbp_pkg::POS_W-1:0]   row;
  logic [rbp_pkg::POS_W-1:0]   col;
  logic [rbp_pkg::RUN_W-1:0]   run;
  logic                        adv;
  logic                        last;

  assign adv  = active && (!out_valid || out_ready);
  assign last = ((row == cur.row_hi) && (col == cur.col_hi)) ||
                (run == rbp_pkg::RUN_W'(rbp_pkg::RESULT_CAP - 1));
  assign pop  = !fifo_stat.empty && (!active || (adv && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (adv && last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
      row <= pop_data.row_lo;
      col <= pop_data.col_lo;
      run <= '0;
    end else if (adv) begin
      run <= run + 1'b1;
      if (col == cur.col_hi) begin
        col <= cur.col_lo;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_row     <= row;
      out_col     <= col;
      out_value   <= cur.value;
      last_of_run <= last;
    end
  end

  // walk stays inside the span rectangle
  a_row_in_span: assert property (@(posedge clk) disable iff (rst)
    active |-> (row >= cur.row_lo) && (row <= cur.row_hi))
    else $error("row walked outside span");

  a_col_in_span: assert property (@(posedge clk) disable iff (rst)
    active |-> (col >= cur.col_lo) && (col <= cur.col_hi))
    else $error("column walked outside span");

  // a run that stops without a marked final result loses the next word's start
  a_run_ends_marked: assert property (@(posedge clk) disable iff (rst)
    (active && adv && !pop) |=> (out_valid && (last_of_run || active)))
    else $error("run ended without a marked final result");

endmodule

`default_nettype wire

### sim/rbp_placement_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbp_placement_checker - padded placement predictor and result comparator
// Watches the register, pixel and result channels of the border padder. It
// keeps its own register copy and position counters, scatters each taken
// pixel into the placements it should cause and compares each result word
// against the oldest one still due.
// ---------------------------------------------------------------------------
module rbp_placement_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [rbp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [rbp_pkg::DIM_W-1:0]              cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic [rbp_pkg::PIX_W-1:0]              pixel_in,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic [rbp_pkg::POS_W-1:0]              out_row,
  input  logic [rbp_pkg::POS_W-1:0]              out_col,
  input  logic [rbp_pkg::PIX_W-1:0]              out_value,
  input  logic                                   last_of_run,
  output int                                     errors,
  output int                                     pending
);

  typedef struct packed {
    logic [rbp_pkg::POS_W-1:0] row;
    logic [rbp_pkg::POS_W-1:0] col;
    logic [rbp_pkg::PIX_W-1:0] value;
    logic                      last;
  } placement_t;

  placement_t                placements_due[$];
  logic [rbp_pkg::DIM_W-1:0] width_reg;
  logic [rbp_pkg::DIM_W-1:0] height_reg;
  logic [rbp_pkg::PAD_W-1:0] pad_reg;
  int unsigned               col_pos;
  int unsigned               row_pos;

  // zero acts as one, anything above the maximum as the maximum
  function automatic int unsigned active_size(input logic [rbp_pkg::DIM_W-1:0] v,
                                              input int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic void scatter_pixel(input logic [rbp_pkg::PIX_W-1:0] v);
    int unsigned w, h, p, rlo, rhi, clo, chi, n;
    placement_t  pl;
    w = active_size(width_reg, rbp_pkg::MAX_WIDTH);
    h = active_size(height_reg, rbp_pkg::MAX_HEIGHT);
    p = pad_reg;
    // counters left out of range by a register write start over
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    rlo = (row_pos == 0) ? 0 : row_pos + p;
    rhi = (row_pos == h - 1) ? row_pos + 2 * p : row_pos + p;
    clo = (col_pos == 0) ? 0 : col_pos + p;
    chi = (col_pos == w - 1) ? col_pos + 2 * p : col_pos + p;
    n = 0;
    for (int unsigned r = rlo; r <= rhi && n < rbp_pkg::RESULT_CAP; r++) begin
      for (int unsigned c = clo; c <= chi && n < rbp_pkg::RESULT_CAP; c++) begin
        pl.row   = rbp_pkg::POS_W'(r);
        pl.col   = rbp_pkg::POS_W'(c);
        pl.value = v;
        pl.last  = (n == rbp_pkg::RESULT_CAP - 1) || (r == rhi && c == chi);
        placements_due.push_back(pl);
        n++;
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  always @(posedge clk) begin
    placement_t due;
    if (rst) begin
      placements_due.delete();
      width_reg  = rbp_pkg::FRAME_WIDTH_RST;
      height_reg = rbp_pkg::FRAME_HEIGHT_RST;
      pad_reg    = rbp_pkg::PAD_WIDTH_RST;
      col_pos    = 0;
      row_pos    = 0;
      errors     = 0;
    end else begin
      // results first: a pixel taken this edge cannot be answered this edge
      if (out_valid && out_ready) begin
        if (placements_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got row %0d col %0d",
                   $time, out_row, out_col, " value %0d last %0d",
                   out_value, last_of_run);
        end else begin
          due = placements_due.pop_front();
          if (out_row !== due.row || out_col !== due.col ||
              out_value !== due.value || last_of_run !== due.last) begin
            errors++;
            $display("%0t: result mismatch: expected row %0d col %0d value %0d last %0d,",
                     $time, due.row, due.col, due.value, due.last,
                     " got row %0d col %0d value %0d last %0d",
                     out_row, out_col, out_value, last_of_run);
          end
        end
      end
      // a pixel taken on a register write edge still sees the old registers
      if (in_valid && in_ready) scatter_pixel(pixel_in);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rbp_pkg::CFG_FRAME_WIDTH:  width_reg  = cfg_data;
          rbp_pkg::CFG_FRAME_HEIGHT: height_reg = cfg_data;
          rbp_pkg::CFG_PAD_WIDTH:    pad_reg    = cfg_data[rbp_pkg::PAD_W-1:0];
          default: ;
        endcase
      end
    end
    pending = placements_due.size();
  end

endmodule

### sim/tb_replicate_border_padder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_replicate_border_padder - stimulus and verdict for the border padder
// Drives register writes and pixel words into the padder under bursty input
// and a varying output stall, with two long output hold-offs to back the
// block up. Prediction and comparison sit in the placement checker.
// ---------------------------------------------------------------------------
module tb_replicate_border_padder;

  // index 3 decodes to no register; a write there must change nothing
  localparam logic [rbp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int STALL_LIMIT  = 4000; // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 16;   // quiet tail after the last result
  localparam int RANDOM_WORDS = 280;
  localparam int LONG_HOLD    = 300;  // receiver hold-off, in cycles

  typedef enum int {ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, PERIODIC} stall_mode_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [rbp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rbp_pkg::DIM_W-1:0]     cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [rbp_pkg::PIX_W-1:0]     pixel_in;
  logic                          out_valid;
  logic                          out_ready;
  logic [rbp_pkg::POS_W-1:0]     out_row;
  logic [rbp_pkg::POS_W-1:0]     out_col;
  logic [rbp_pkg::PIX_W-1:0]     out_value;
  logic                          last_of_run;

  int          errors;
  int          pending;       // placements still owed by the block
  int          hold_req;      // bumped by stimulus to ask for a long hold-off
  bit          quiet_input;   // no gaps between input words this phase
  int unsigned burst_left;

  replicate_border_padder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_in    (pixel_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_value   (out_value),
    .last_of_run (last_of_run)
  );

  rbp_placement_checker u_placement_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_in    (pixel_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_value   (out_value),
    .last_of_run (last_of_run),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Drop valid for a gap set by n. Ends on a negedge; the next word goes up on the
  // following one, so valid never falls and rises in the same step.
  task automatic hold_input(input int unsigned n);
    if (n == 0) return;
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Offer one pixel word and wait for it to be taken. Outside quiet phases
  // words go out in bursts of random length with random gaps between them.
  task automatic push_pixel(input logic [rbp_pkg::PIX_W-1:0] v);
    if (!quiet_input) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        hold_input($urandom_range(0, 12));
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    pixel_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rbp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rbp_pkg::DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering words and wait until every owed placement has come out.
  // Each pixel yields at least one result, so an empty list means idle.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_frame(input logic [rbp_pkg::DIM_W-1:0] w,
                           input logic [rbp_pkg::DIM_W-1:0] h,
                           input logic [rbp_pkg::DIM_W-1:0] pad_data);
    settle();
    write_reg(rbp_pkg::CFG_FRAME_WIDTH, w);
    write_reg(rbp_pkg::CFG_FRAME_HEIGHT, h);
    write_reg(rbp_pkg::CFG_PAD_WIDTH, pad_data);
  endtask

  // zero, one, the exact maximum and an oversized value
  function automatic logic [rbp_pkg::DIM_W-1:0] extreme_dim();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return rbp_pkg::DIM_W'(1);
      2:       return rbp_pkg::DIM_W'(rbp_pkg::MAX_WIDTH);
      default: return '1;
    endcase
  endfunction

  // Receiver: draws its stall pattern at random from four modes. When stimulus
  // asks, it holds out_ready low for the LONG_HOLD hold-off so the span queue
  // fills and the block pushes back on its input.
  initial begin
    int          hold_seen;
    int unsigned tick;
    stall_mode_t mode;
    out_ready = 1'b0;
    hold_seen = 0;
    tick      = 0;
    mode      = ALWAYS_READY;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (tick % 64 == 0) mode = stall_mode_t'($urandom_range(0, 3));
      tick++;
      case (mode)
        ALWAYS_READY:   out_ready <= 1'b1;
        COIN_FLIP:      out_ready <= 1'($urandom_range(0, 1));
        MOSTLY_STALLED: out_ready <= ($urandom_range(0, 3) == 0);
        default:        out_ready <= ((tick % 8) < 5);
      endcase
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("tb_replicate_border_padder failed");
    $finish;
  end

  initial begin
    logic [rbp_pkg::DIM_W-1:0] w;
    logic [rbp_pkg::DIM_W-1:0] h;
    logic [rbp_pkg::PAD_W-1:0] p;
    int                        sent;
    int                        phase;
    int                        len;

    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = rbp_pkg::CFG_FRAME_WIDTH;
    cfg_data    = '0;
    in_valid    = 1'b0;
    pixel_in    = '0;
    hold_req    = 0;
    quiet_input = 1'b0;
    burst_left  = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed part ---

    // reset registers: 2048 x 2048, border 4; top-left corner then top edge
    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'hA5);

    // width 0 acts as one column, border 7 from an all-ones write; the
    // column counter left at 3 has to start over. Top and bottom corners
    // cover 8 x 15 places and get cut at the result cap.
    set_frame(rbp_pkg::DIM_W'(0), rbp_pkg::DIM_W'(3), '1);
    write_reg(CFG_SPARE, '1);
    push_pixel(8'h5A);
    push_pixel(8'h00);
    push_pixel(8'hFF);

    // oversized width acts as the maximum, height 0 as a single row, no border
    set_frame('1, rbp_pkg::DIM_W'(0), rbp_pkg::DIM_W'(0));
    push_pixel(8'h3C);
    push_pixel(8'hC3);
    push_pixel(8'h81);

    // 3 x 2 frame, border 1 with junk above the pad bits; one word past the
    // frame end checks the wrap back to the top-left corner
    set_frame(rbp_pkg::DIM_W'(3), rbp_pkg::DIM_W'(2), 12'hFF9);
    for (int i = 0; i < 7; i++) push_pixel(rbp_pkg::PIX_W'($urandom_range(0, 255)));

    // single pixel frame, widest border: every word is capped at 64 results
    set_frame(rbp_pkg::DIM_W'(1), rbp_pkg::DIM_W'(1), rbp_pkg::DIM_W'(7));
    push_pixel(8'h7E);
    push_pixel(8'h18);

    // exact maxima, no border
    set_frame(rbp_pkg::DIM_W'(rbp_pkg::MAX_WIDTH), rbp_pkg::DIM_W'(rbp_pkg::MAX_HEIGHT),
              rbp_pkg::DIM_W'(0));
    push_pixel(8'hE7);
    push_pixel(8'h42);

    // --- random part: small frames mostly, with the odd extreme size ---
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      w = rbp_pkg::DIM_W'($urandom_range(1, 10));
      h = rbp_pkg::DIM_W'($urandom_range(1, 6));
      p = rbp_pkg::PAD_W'($urandom_range(0, 7));
      if ($urandom_range(0, 5) == 0) w = extreme_dim();
      if ($urandom_range(0, 5) == 0) h = extreme_dim();
      set_frame(w, h, (rbp_pkg::DIM_W'($urandom_range(0, 511)) << rbp_pkg::PAD_W) |
                      rbp_pkg::DIM_W'(p));
      quiet_input = ($urandom_range(0, 3) == 0);
      burst_left  = 0;
      if (phase == 1 || phase == 5) hold_req++;
      len = $urandom_range(10, 50);
      repeat (len) push_pixel(rbp_pkg::PIX_W'($urandom_range(0, 255)));
      sent += len;
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb_replicate_border_padder passed");
    else
      $display("tb_replicate_border_padder failed");
    $finish;
  end

endmodule

### filelist.f
rtl/rbp_pkg.sv
rtl/rbp_front.sv
rtl/rbp_fifo.sv
rtl/rbp_back.sv
rtl/replicate_border_padder.sv
sim/rbp_placement_checker.sv
sim/tb_replicate_border_padder.sv
